>>> rtl/tpat_pkg.sv
package tpat_pkg;

  localparam int PAGE_BYTES  = 256;
  localparam int NUM_PAGES   = 64;
  localparam int NUM_FRAMES  = 16;
  localparam int TLB_ENTRIES = 8;

  localparam int OFF_W = $clog2(PAGE_BYTES);
  localparam int PG_W  = $clog2(NUM_PAGES);
  localparam int FR_W  = $clog2(NUM_FRAMES);
  localparam int TI_W  = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;

  localparam int VA_W  = 14;
  localparam int VPN_W = VA_W - OFF_W;
  localparam int PA_W  = 12;
  localparam int DA_W  = 21;
  localparam int DB_W  = 20;
  localparam int CI_W  = 2;

  // request kinds
  localparam logic [1:0] KIND_READ  = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_FLUSH = 2'd2;
  localparam logic [1:0] KIND_RSVD  = 2'd3;

  // configuration register indexes
  localparam logic [CI_W-1:0] CFG_USE_TLB        = 2'd0;
  localparam logic [CI_W-1:0] CFG_REPLACE_POLICY = 2'd1;
  localparam logic [CI_W-1:0] CFG_DISK_BASE      = 2'd2;

  typedef struct packed {
    logic [1:0]      kind;
    logic [VA_W-1:0] vaddr;
  } tpat_req_t;

  typedef struct packed {
    logic [PA_W-1:0] paddr;
    logic            tlb_hit;
    logic            page_fault;
    logic [DA_W-1:0] fetch_disk_address;
    logic            writeback_valid;
    logic [3:0]      writeback_frame;
    logic [DA_W-1:0] writeback_disk_address;
    logic            addr_error;
    logic            last;
  } tpat_res_t;

  typedef struct packed {
    logic            use_tlb;
    logic            replace_policy;
    logic [DB_W-1:0] disk_base;
  } tpat_cfg_t;

  typedef struct packed {
    logic            valid;
    logic            referenced;
    logic            dirty;
    logic [PG_W-1:0] page;
    logic [FR_W-1:0] frame;
  } tlb_entry_t;

  typedef enum logic [2:0] {
    RES_ZERO,
    RES_ERR,
    RES_HIT,
    RES_WALK,
    RES_FL_MID,
    RES_FL_LAST
  } res_sel_e;

  typedef struct packed {
    logic     latch;
    logic     tlb_touch;
    logic     rd_page;
    logic     walk;
    logic     evict;
    logic     fill;
    logic     update;
    logic     tfill;
    logic     fl_merge;
    logic     fl_rd;
    logic     fl_chk;
    logic     out_load;
    res_sel_e res_sel;
  } tpat_cmd_t;

  typedef struct packed {
    logic is_flush;
    logic is_bad;
    logic addr_err;
    logic hit;
    logic pt_valid;
    logic out_free;
    logic merge_last;
    logic scan_last;
    logic scan_emit;
    logic pend;
  } tpat_sts_t;

  function automatic logic [DA_W-1:0] disk_addr(input logic [DB_W-1:0] base,
                                                input logic [PG_W-1:0] page);
    disk_addr = DA_W'(base) + DA_W'({page, {OFF_W{1'b0}}});
  endfunction

endpackage

>>> rtl/tlb_paged_address_translator_core.sv
// channel   direction  handshake                  payload
// in        input      in_valid_i / in_ready_o    in_req_i   (kind, vaddr)
// out       output     out_valid_o / out_ready_i  out_res_o  (translation or flush result)
// cfg       input      cfg_we_i                   cfg_index_i, cfg_data_i
//
// one request at a time; a tlb hit answers from decode, a resident miss steps through
// page table read, update and tlb refill, and a page fault adds evict and fill
// flush merges the tlb dirty bits, then does one page table read per page
// reset clears the tlb, restores identity mapping and lru/fifo order
// a full output register stalls the sequencer in its result steps
module tlb_paged_address_translator_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  tpat_pkg::tpat_req_t         in_req_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output tpat_pkg::tpat_res_t         out_res_o,
  input  logic                        cfg_we_i,
  input  logic [tpat_pkg::CI_W-1:0]   cfg_index_i,
  input  logic [tpat_pkg::DB_W-1:0]   cfg_data_i
);
  import tpat_pkg::*;

  tpat_cfg_t cfg_q;
  tpat_cmd_t cmd;
  tpat_sts_t sts;

  // configuration registers, writes to unused indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.use_tlb        <= 1'b1;
      cfg_q.replace_policy <= 1'b0;
      cfg_q.disk_base      <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_USE_TLB:        cfg_q.use_tlb        <= cfg_data_i[0];
        CFG_REPLACE_POLICY: cfg_q.replace_policy <= cfg_data_i[0];
        CFG_DISK_BASE:      cfg_q.disk_base      <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // sequencer: decode, walk, evict, fill, lru update, tlb refill, flush scan
  tpat_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // tlb, page table memories, frame tables and the output register
  tpat_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .req_i       (in_req_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (out_res_o)
  );

endmodule

>>> rtl/tpat_ctrl.sv
module tpat_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  tpat_pkg::tpat_sts_t sts_i,
  output tpat_pkg::tpat_cmd_t cmd_o
);
  import tpat_pkg::*;

  typedef enum logic [10:0] {
    ST_IDLE     = 11'b00000000001,
    ST_DECODE   = 11'b00000000010,
    ST_PT_RD    = 11'b00000000100,
    ST_VICT     = 11'b00000001000,
    ST_FILL     = 11'b00000010000,
    ST_UPDATE   = 11'b00000100000,
    ST_TFILL    = 11'b00001000000,
    ST_FL_MERGE = 11'b00010000000,
    ST_FL_RD    = 11'b00100000000,
    ST_FL_CHK   = 11'b01000000000,
    ST_FL_END   = 11'b10000000000
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.res_sel = RES_ZERO;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (sts_i.is_flush) begin
          state_d = ST_FL_MERGE;
        end else if (sts_i.is_bad || sts_i.addr_err || sts_i.hit) begin
          if (sts_i.out_free) begin
            cmd_o.out_load = 1'b1;
            if (sts_i.is_bad) begin
              cmd_o.res_sel = RES_ZERO;
            end else if (sts_i.addr_err) begin
              cmd_o.res_sel = RES_ERR;
            end else begin
              cmd_o.res_sel   = RES_HIT;
              cmd_o.tlb_touch = 1'b1;
            end
            state_d = ST_IDLE;
          end
        end else begin
          cmd_o.rd_page = 1'b1;
          state_d = ST_PT_RD;
        end
      end
      ST_PT_RD: begin
        cmd_o.walk = 1'b1;
        state_d = sts_i.pt_valid ? ST_UPDATE : ST_VICT;
      end
      ST_VICT: begin
        cmd_o.evict = 1'b1;
        state_d = ST_FILL;
      end
      ST_FILL: begin
        cmd_o.fill = 1'b1;
        state_d = ST_UPDATE;
      end
      ST_UPDATE: begin
        cmd_o.update = 1'b1;
        state_d = ST_TFILL;
      end
      ST_TFILL: begin
        if (sts_i.out_free) begin
          cmd_o.tfill    = 1'b1;
          cmd_o.out_load = 1'b1;
          cmd_o.res_sel  = RES_WALK;
          state_d = ST_IDLE;
        end
      end
      ST_FL_MERGE: begin
        cmd_o.fl_merge = 1'b1;
        if (sts_i.merge_last) begin
          state_d = ST_FL_RD;
        end
      end
      ST_FL_RD: begin
        cmd_o.fl_rd = 1'b1;
        state_d = ST_FL_CHK;
      end
      ST_FL_CHK: begin
        // a found page pushes out the one held back, which needs the output free
        if (!(sts_i.scan_emit && sts_i.pend && !sts_i.out_free)) begin
          cmd_o.fl_chk   = 1'b1;
          cmd_o.out_load = sts_i.scan_emit && sts_i.pend;
          cmd_o.res_sel  = RES_FL_MID;
          state_d = sts_i.scan_last ? ST_FL_END : ST_FL_RD;
        end
      end
      ST_FL_END: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.res_sel  = sts_i.pend ? RES_FL_LAST : RES_ZERO;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> rtl/tpat_dp.sv
module tpat_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tpat_pkg::tpat_cfg_t cfg_i,
  input  tpat_pkg::tpat_req_t req_i,
  input  tpat_pkg::tpat_cmd_t cmd_i,
  output tpat_pkg::tpat_sts_t sts_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output tpat_pkg::tpat_res_t res_o
);
  import tpat_pkg::*;

  // latched request
  logic [1:0]       kind_q;
  logic [VA_W-1:0]  va_q;
  logic [VPN_W-1:0] vpn;
  logic [PG_W-1:0]  page;
  logic [OFF_W-1:0] off;
  logic             is_write;

  // translation state
  tlb_entry_t       tlb_q   [TLB_ENTRIES];
  logic [FR_W-1:0]  lru_q   [NUM_FRAMES];
  logic [FR_W-1:0]  lru_d   [NUM_FRAMES];
  logic [PG_W-1:0]  owner_q [NUM_FRAMES];
  logic [NUM_FRAMES-1:0] holds_q;
  logic [FR_W-1:0]  fifo_q;

  // page table memories, unwritten entries read as reset contents
  logic [FR_W:0]    info_mem  [NUM_PAGES];
  logic             dirty_mem [NUM_PAGES];
  logic [NUM_PAGES-1:0] info_wr_q, dirty_wr_q;
  logic [FR_W:0]    info_rd_q;
  logic             dirty_rd_q, info_rdw_q, dirty_rdw_q;
  logic [PG_W-1:0]  rd_addr_q;
  logic             rd_en;
  logic [PG_W-1:0]  rd_addr;
  logic             info_we, dirty_we, dirty_wd;
  logic [PG_W-1:0]  info_wa, dirty_wa;
  logic [FR_W:0]    info_wd;
  logic             rd_valid, rd_dirty;
  logic [FR_W-1:0]  rd_frame;

  // walk registers
  logic [FR_W-1:0]  frame_q, victim_q;
  logic [PG_W-1:0]  vp_q;
  logic             fault_q, vp_holds_q, drop_dirty_q, wb_valid_q;
  logic [DA_W-1:0]  wb_addr_q;

  // flush registers
  logic [TI_W-1:0]  merge_idx_q;
  logic [PG_W-1:0]  scan_idx_q;
  logic             pend_q;
  logic [FR_W-1:0]  pend_frame_q;
  logic [PG_W-1:0]  pend_page_q;

  tpat_res_t        res_q, res_c;
  logic             out_valid_q;

  // combinational helpers
  logic             hit_c;
  logic [TI_W-1:0]  hit_idx;
  logic [FR_W-1:0]  victim_c;
  logic [PG_W-1:0]  vp_c;
  logic [TLB_ENTRIES-1:0] vp_match;
  logic [TLB_ENTRIES-1:0] tlb_dirty;
  logic             any_inv;
  logic [TI_W-1:0]  inv_idx, sweep_idx, slot;
  logic [NUM_FRAMES-1:0] lru_match, lru_shift;
  logic             acc;

  assign vpn      = va_q[VA_W-1:OFF_W];
  assign page     = PG_W'(vpn);
  assign off      = va_q[OFF_W-1:0];
  assign is_write = (kind_q == KIND_WRITE);

  assign rd_valid = info_rdw_q ? info_rd_q[FR_W]
                               : (32'(rd_addr_q) < NUM_FRAMES);
  assign rd_frame = info_rdw_q ? info_rd_q[FR_W-1:0]
                               : ((32'(rd_addr_q) < NUM_FRAMES) ? FR_W'(rd_addr_q) : '0);
  assign rd_dirty = dirty_rdw_q && dirty_rd_q;

  assign victim_c = cfg_i.replace_policy ? fifo_q : lru_q[NUM_FRAMES-1];
  assign vp_c     = owner_q[victim_c];

  always_comb begin
    hit_c   = 1'b0;
    hit_idx = '0;
    any_inv = 1'b0;
    inv_idx = '0;
    sweep_idx = TI_W'(TLB_ENTRIES - 1);
    for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
      vp_match[i]  = tlb_q[i].valid && (tlb_q[i].page == vp_c);
      tlb_dirty[i] = tlb_q[i].dirty;
      if (tlb_q[i].valid && (tlb_q[i].page == page)) begin
        hit_c   = 1'b1;
        hit_idx = TI_W'(i);
      end
      if (!tlb_q[i].valid) begin
        any_inv = 1'b1;
        inv_idx = TI_W'(i);
      end
      if (!tlb_q[i].referenced && (i != TLB_ENTRIES - 1)) begin
        sweep_idx = TI_W'(i);
      end
    end
    slot = any_inv ? inv_idx : sweep_idx;
  end

  // move-to-front: every position at or below the match index takes its neighbor
  always_comb begin
    acc = 1'b0;
    for (int j = NUM_FRAMES - 1; j >= 0; j--) begin
      lru_match[j] = (lru_q[j] == frame_q);
      acc = acc | lru_match[j];
      lru_shift[j] = acc;
    end
    for (int j = 0; j < NUM_FRAMES; j++) begin
      if (!lru_shift[j]) begin
        lru_d[j] = lru_q[j];
      end else if (j == 0) begin
        lru_d[j] = frame_q;
      end else begin
        lru_d[j] = lru_q[j-1];
      end
    end
  end

  // memory port steering
  always_comb begin
    info_we  = 1'b0;
    info_wa  = vp_q;
    info_wd  = {1'b0, victim_q};
    dirty_we = 1'b0;
    dirty_wa = page;
    dirty_wd = 1'b1;
    if (cmd_i.evict && vp_holds_q) begin
      info_we = 1'b1;
    end
    if (cmd_i.fill) begin
      info_we  = 1'b1;
      info_wa  = page;
      info_wd  = {1'b1, victim_q};
      dirty_we = 1'b1;
      dirty_wd = is_write;
    end
    if (cmd_i.update && is_write) begin
      dirty_we = 1'b1;
    end
    if (cmd_i.tfill && cfg_i.use_tlb && !any_inv && tlb_q[slot].dirty) begin
      dirty_we = 1'b1;
      dirty_wa = tlb_q[slot].page;
    end
    if (cmd_i.fl_merge && tlb_q[merge_idx_q].valid && tlb_q[merge_idx_q].dirty) begin
      dirty_we = 1'b1;
      dirty_wa = tlb_q[merge_idx_q].page;
    end
    rd_en   = cmd_i.rd_page || cmd_i.fl_rd || (cmd_i.walk && !rd_valid);
    rd_addr = cmd_i.rd_page ? page : (cmd_i.walk ? vp_c : scan_idx_q);
  end

  always_ff @(posedge clk_i) begin
    if (info_we) begin
      info_mem[info_wa] <= info_wd;
    end
    if (dirty_we) begin
      dirty_mem[dirty_wa] <= dirty_wd;
    end
    if (rd_en) begin
      info_rd_q  <= info_mem[rd_addr];
      dirty_rd_q <= dirty_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      info_wr_q   <= '0;
      dirty_wr_q  <= '0;
      info_rdw_q  <= 1'b0;
      dirty_rdw_q <= 1'b0;
      rd_addr_q   <= '0;
    end else begin
      if (info_we) begin
        info_wr_q[info_wa] <= 1'b1;
      end
      if (dirty_we) begin
        dirty_wr_q[dirty_wa] <= 1'b1;
      end
      if (rd_en) begin
        info_rdw_q  <= info_wr_q[rd_addr];
        dirty_rdw_q <= dirty_wr_q[rd_addr];
        rd_addr_q   <= rd_addr;
      end
    end
  end

  // result selection
  always_comb begin
    res_c = '0;
    res_c.last = 1'b1;
    case (cmd_i.res_sel)
      RES_ZERO: begin
      end
      RES_ERR: begin
        res_c.addr_error = 1'b1;
      end
      RES_HIT: begin
        res_c.paddr   = PA_W'({tlb_q[hit_idx].frame, off});
        res_c.tlb_hit = 1'b1;
      end
      RES_WALK: begin
        res_c.paddr            = PA_W'({frame_q, off});
        res_c.page_fault       = fault_q;
        res_c.fetch_disk_address = fault_q ? disk_addr(cfg_i.disk_base, page) : '0;
        res_c.writeback_valid  = wb_valid_q;
        res_c.writeback_frame  = wb_valid_q ? 4'(victim_q) : '0;
        res_c.writeback_disk_address = wb_valid_q ? wb_addr_q : '0;
      end
      RES_FL_MID, RES_FL_LAST: begin
        res_c.writeback_valid  = 1'b1;
        res_c.writeback_frame  = 4'(pend_frame_q);
        res_c.writeback_disk_address = disk_addr(cfg_i.disk_base, pend_page_q);
        res_c.last = (cmd_i.res_sel == RES_FL_LAST);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      kind_q <= req_i.kind;
      va_q   <= req_i.vaddr;
    end
    if (cmd_i.walk) begin
      if (rd_valid) begin
        frame_q <= rd_frame;
      end else begin
        frame_q    <= victim_c;
        victim_q   <= victim_c;
        vp_q       <= vp_c;
        vp_holds_q <= holds_q[victim_c];
        drop_dirty_q <= |(vp_match & {TLB_ENTRIES{holds_q[victim_c]}} & tlb_dirty);
      end
    end
    if (cmd_i.evict) begin
      wb_addr_q <= disk_addr(cfg_i.disk_base, vp_q);
    end
    if (cmd_i.fl_chk && rd_valid && rd_dirty) begin
      pend_frame_q <= rd_frame;
      pend_page_q  <= rd_addr_q;
    end
    if (cmd_i.out_load) begin
      res_q <= res_c;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TLB_ENTRIES; i++) begin
        tlb_q[i] <= '0;
      end
      for (int i = 0; i < NUM_FRAMES; i++) begin
        lru_q[i]   <= FR_W'(NUM_FRAMES - 1 - i);
        owner_q[i] <= PG_W'(i);
        holds_q[i] <= (i < NUM_PAGES);
      end
      fifo_q      <= FR_W'(NUM_FRAMES - 1);
      fault_q     <= 1'b0;
      wb_valid_q  <= 1'b0;
      merge_idx_q <= '0;
      scan_idx_q  <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.latch) begin
        fault_q     <= 1'b0;
        wb_valid_q  <= 1'b0;
        merge_idx_q <= '0;
        scan_idx_q  <= '0;
        pend_q      <= 1'b0;
      end
      if (cmd_i.tlb_touch) begin
        tlb_q[hit_idx].referenced <= 1'b1;
        tlb_q[hit_idx].dirty      <= tlb_q[hit_idx].dirty | is_write;
      end
      if (cmd_i.walk && !rd_valid) begin
        fault_q <= 1'b1;
        if (cfg_i.replace_policy) begin
          fifo_q <= (victim_c == '0) ? FR_W'(NUM_FRAMES - 1) : victim_c - 1'b1;
        end
        if (holds_q[victim_c]) begin
          for (int i = 0; i < TLB_ENTRIES; i++) begin
            if (vp_match[i]) begin
              tlb_q[i].valid <= 1'b0;
            end
          end
        end
      end
      if (cmd_i.evict) begin
        wb_valid_q <= vp_holds_q && (rd_dirty || drop_dirty_q);
      end
      if (cmd_i.fill) begin
        owner_q[victim_q] <= page;
        holds_q[victim_q] <= 1'b1;
      end
      if (cmd_i.update && !cfg_i.replace_policy) begin
        lru_q <= lru_d;
      end
      if (cmd_i.tfill && cfg_i.use_tlb) begin
        if (!any_inv) begin
          for (int i = 0; i < TLB_ENTRIES; i++) begin
            if (TI_W'(i) < slot) begin
              tlb_q[i].referenced <= 1'b0;
            end
          end
        end
        tlb_q[slot] <= '{valid: 1'b1, referenced: 1'b1, dirty: 1'b0,
                         page: page, frame: frame_q};
      end
      if (cmd_i.fl_merge) begin
        merge_idx_q <= merge_idx_q + 1'b1;
      end
      if (cmd_i.fl_chk) begin
        scan_idx_q <= scan_idx_q + 1'b1;
        if (rd_valid && rd_dirty) begin
          pend_q <= 1'b1;
        end
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

  always_comb begin
    sts_o            = '0;
    sts_o.is_flush   = (kind_q == KIND_FLUSH);
    sts_o.is_bad     = (kind_q == KIND_RSVD);
    sts_o.addr_err   = (32'(vpn) >= NUM_PAGES);
    sts_o.hit        = cfg_i.use_tlb && hit_c;
    sts_o.pt_valid   = rd_valid;
    sts_o.out_free   = !out_valid_q || out_ready_i;
    sts_o.merge_last = (merge_idx_q == TI_W'(TLB_ENTRIES - 1));
    sts_o.scan_last  = (scan_idx_q == PG_W'(NUM_PAGES - 1));
    sts_o.scan_emit  = rd_valid && rd_dirty;
    sts_o.pend       = pend_q;
  end

`ifndef SYNTHESIS
  a_out_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> (!out_valid_q || out_ready_i))
    else $error("result loaded while output register still held");

  a_walk_only_on_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.walk && cfg_i.use_tlb) |-> !hit_c)
    else $error("page walk started although tlb holds the page");

  a_victim_dropped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.evict && vp_holds_q) |-> !(|(vp_match) && (vp_c == vp_q)))
    else $error("tlb still names the evicted page");
`endif

endmodule
